[sv/sigpmd_pkg.sv]
// ----------------------------------------------------------------------------
// sigpmd_pkg
// Types and constants of the signal pending mask and delivery controller.
// ----------------------------------------------------------------------------
package sigpmd_pkg;

    localparam int ADDR_W  = 48;
    localparam int SET_W   = 64;
    localparam int FLAGS_W = 32;
    localparam int SIG_W   = 8;
    localparam int KIND_W  = 3;
    localparam int HOW_W   = 2;

    localparam int S_TDATA_W = 256;
    localparam int M_TDATA_W = 360;

    localparam logic [KIND_W-1:0] KIND_SEND    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SETACT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SETMASK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SIGRET  = 3'd4;

    localparam logic [HOW_W-1:0] HOW_BLOCK   = 2'd0;
    localparam logic [HOW_W-1:0] HOW_UNBLOCK = 2'd1;
    localparam logic [HOW_W-1:0] HOW_SET     = 2'd2;

    localparam logic [SIG_W-1:0] SIG_KILL  = 8'd9;
    localparam logic [SIG_W-1:0] SIG_STOP  = 8'd19;
    localparam logic [SIG_W-1:0] SIG_CHLD  = 8'd17;
    localparam logic [SIG_W-1:0] SIG_CONT  = 8'd18;
    localparam logic [SIG_W-1:0] SIG_WINCH = 8'd28;

    localparam logic [SET_W-1:0]   NOBLOCK_MASK = (64'd1 << 8) | (64'd1 << 18);
    localparam logic [FLAGS_W-1:0] NODEFER_BIT  = 32'h4000_0000;
    localparam logic [ADDR_W-1:0]  ALIGN_MASK   = ~48'hF;
    localparam logic [ADDR_W-1:0]  RET_SLOT     = 48'd8;
    localparam logic [ADDR_W-1:0]  MIN_RESTORER = 48'd2;
    localparam logic [SIG_W-1:0]   EXIT_BASE    = 8'd128;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_IGNORED,
        OUT_TERM,
        OUT_HANDLER,
        OUT_RESTORE
    } outcome_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [3:0]         pad;
        logic               is_user;
        logic [ADDR_W-1:0]  stack_ptr;
        logic [ADDR_W-1:0]  restorer_addr;
        logic [FLAGS_W-1:0] flags_word;
        logic [ADDR_W-1:0]  handler_addr;
        logic [SET_W-1:0]   bits;
        logic               has_new;
        logic [HOW_W-1:0]   how;
        logic [SIG_W-1:0]   signal;
    } item_t;

    // result item without outcome, last field in the lowest bits
    typedef struct packed {
        logic [6:0]         pad;
        logic [ADDR_W-1:0]  ctx_addr;
        logic [ADDR_W-1:0]  new_sp;
        logic [ADDR_W-1:0]  new_pc;
        logic [7:0]         term_code;
        logic [6:0]         signal_out;
        logic [ADDR_W-1:0]  old_restorer;
        logic [FLAGS_W-1:0] old_flags;
        logic [ADDR_W-1:0]  old_handler;
        logic [SET_W-1:0]   old_bits;
        logic               wake;
        logic               status;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  handler;
        logic [SET_W-1:0]   amask;
        logic [FLAGS_W-1:0] flags;
        logic [ADDR_W-1:0]  restorer;
    } act_entry_t;

    function automatic logic [SET_W-1:0] unblockable(input logic [SET_W-1:0] m);
        return m & ~NOBLOCK_MASK;
    endfunction

endpackage

[sv/signal_pending_mask_delivery.sv]
// ----------------------------------------------------------------------------
// signal_pending_mask_delivery
// Per-task signal controller: pending set, blocked mask, action table memory,
// handler frame entry and return.
// ----------------------------------------------------------------------------
// Flow: one item in work at a time; s_tready is high only in the idle state.
//   The result and the action table write back are registered together from
//   the captured item and table read; the block stays busy while m_tready is low.
// Reset: control state and the table's per-entry valid bits clear on reset;
//   no clearing pass, items are taken right after reset.
module signal_pending_mask_delivery #(
    parameter int NUM_SIGNALS = 64,
    parameter int FRAME_BYTES = 192
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // signal, how, has_new, bits, handler_addr, flags_word, restorer_addr,
    // stack_ptr, is_user
    input  logic [sigpmd_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, wake, old_bits, old_handler, old_flags, old_restorer, signal_out,
    // term_code, new_pc, new_sp, ctx_addr
    output logic [sigpmd_pkg::M_TDATA_W-1:0] m_tdata,
    // outcome
    output logic [2:0]                      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [47:0]                     cfg_data
);
    import sigpmd_pkg::*;

    localparam int IDX_W = $clog2(NUM_SIGNALS);
    localparam logic [SIG_W-1:0]  NUM_SIG   = SIG_W'(NUM_SIGNALS);
    localparam logic [ADDR_W-1:0] FRAME_SZ  = ADDR_W'(FRAME_BYTES);
    localparam logic [SET_W-1:0]  VALID_SET = (64'd1 << NUM_SIGNALS) - 64'd1;

    state_t state_reg, state_next;

    item_t               in_item;
    item_t               item_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [ADDR_W-1:0]   stack_floor_reg;
    logic [SET_W-1:0]    pending_reg, pending_next;
    logic [SET_W-1:0]    blocked_reg, blocked_next;
    logic [SET_W-1:0]    saved_reg, saved_next;
    logic [ADDR_W-1:0]   active_reg, active_next;
    logic [NUM_SIGNALS-1:0] entry_vld_reg;

    act_entry_t          act_mem [NUM_SIGNALS];
    act_entry_t          rd_entry_reg;
    logic                rd_vld_reg;
    act_entry_t          entry;

    logic [IDX_W-1:0]    sel_reg, sel_next;
    logic                dlv_go_reg, dlv_go_next;
    logic [ADDR_W-1:0]   fa_reg, fa_next;
    logic                sp_short_reg, sp_short_next;
    logic                sig_ok_reg, sig_ok_next;

    logic [SET_W-1:0]    ready_set;
    logic [SIG_W-1:0]    in_sig_m1;
    logic [SIG_W-1:0]    item_sig_m1;
    logic [IDX_W-1:0]    rd_idx;
    logic                rd_en;
    logic                in_accept;

    logic                exec_done;
    logic                wr_en;
    logic [SET_W-1:0]    send_bit;
    logic [SET_W-1:0]    dlv_bit;
    logic [SIG_W-1:0]    dlv_sig;
    logic [ADDR_W-1:0]   ra;
    logic                dflt_ign;
    logic                fault;
    logic [SET_W-1:0]    mask_calc;
    result_t             res;
    outcome_t            outcome;

    logic                m_tvalid_reg;
    result_t             m_tdata_reg;
    outcome_t            m_tuser_reg;

    assign in_item   = item_t'(s_tdata);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // accept-side decode
    assign ready_set = pending_reg & ~blocked_reg & VALID_SET;
    assign in_sig_m1 = in_item.signal - SIG_W'(1);

    always_comb begin
        sel_next = '0;
        for (int k = NUM_SIGNALS - 1; k >= 0; k--) begin
            if (ready_set[k]) begin
                sel_next = IDX_W'(k);
            end
        end
    end

    assign sig_ok_next   = (in_item.signal != '0) && (in_item.signal <= NUM_SIG);
    assign dlv_go_next   = in_item.is_user && (active_reg == '0) && (|ready_set);
    assign fa_next       = (in_item.stack_ptr - FRAME_SZ) & ALIGN_MASK;
    assign sp_short_next = in_item.stack_ptr < FRAME_SZ;
    assign rd_idx        = (s_tuser == KIND_DELIVER) ? sel_next : in_sig_m1[IDX_W-1:0];
    assign rd_en         = in_accept &&
                           ((s_tuser == KIND_DELIVER) || ((s_tuser == KIND_SETACT) && sig_ok_next));

    // execute-side logic
    assign exec_done   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign entry       = rd_vld_reg ? rd_entry_reg : '0;
    assign item_sig_m1 = item_reg.signal - SIG_W'(1);
    assign send_bit    = SET_W'(1) << item_sig_m1[5:0];
    assign dlv_bit     = SET_W'(1) << sel_reg;
    assign dlv_sig     = SIG_W'(sel_reg) + SIG_W'(1);
    assign ra          = fa_reg - RET_SLOT;
    assign dflt_ign    = (dlv_sig == SIG_CHLD) || (dlv_sig == SIG_CONT) || (dlv_sig == SIG_WINCH);
    assign fault       = (entry.handler == '0) || (entry.restorer < MIN_RESTORER) ||
                         sp_short_reg || (fa_reg < stack_floor_reg) ||
                         (fa_reg < RET_SLOT) || (ra < stack_floor_reg);

    always_comb begin
        res          = '0;
        outcome      = OUT_NONE;
        pending_next = pending_reg;
        blocked_next = blocked_reg;
        saved_next   = saved_reg;
        active_next  = active_reg;
        wr_en        = 1'b0;
        mask_calc    = blocked_reg;
        case (kind_reg)
            KIND_SEND: begin
                if (!sig_ok_reg) begin
                    res.status = 1'b1;
                end else begin
                    pending_next = pending_reg | send_bit;
                    res.wake     = 1'b1;
                end
            end
            KIND_SETACT: begin
                if (!sig_ok_reg) begin
                    res.status = 1'b1;
                end else begin
                    res.old_bits     = entry.amask;
                    res.old_handler  = entry.handler;
                    res.old_flags    = entry.flags;
                    res.old_restorer = entry.restorer;
                    if (item_reg.has_new) begin
                        if (item_reg.signal == SIG_KILL || item_reg.signal == SIG_STOP) begin
                            res.status = 1'b1;
                        end else begin
                            wr_en = 1'b1;
                        end
                    end
                end
            end
            KIND_SETMASK: begin
                res.old_bits = blocked_reg;
                if (item_reg.has_new) begin
                    case (item_reg.how)
                        HOW_BLOCK:   mask_calc = blocked_reg | item_reg.bits;
                        HOW_UNBLOCK: mask_calc = blocked_reg & ~item_reg.bits;
                        HOW_SET:     mask_calc = item_reg.bits;
                        default:     res.status = 1'b1;
                    endcase
                    if (!res.status) begin
                        blocked_next = unblockable(mask_calc);
                    end
                end
            end
            KIND_DELIVER: begin
                if (dlv_go_reg) begin
                    pending_next   = pending_reg & ~dlv_bit;
                    res.signal_out = dlv_sig[6:0];
                    if (entry.handler == ADDR_W'(1) || (entry.handler == '0 && dflt_ign)) begin
                        outcome = OUT_IGNORED;
                    end else if (fault) begin
                        outcome       = OUT_TERM;
                        res.term_code = EXIT_BASE + dlv_sig;
                    end else begin
                        outcome          = OUT_HANDLER;
                        saved_next       = blocked_reg;
                        active_next      = fa_reg;
                        res.old_bits     = blocked_reg;
                        mask_calc        = blocked_reg | entry.amask;
                        if ((entry.flags & NODEFER_BIT) == '0) begin
                            mask_calc = mask_calc | dlv_bit;
                        end
                        blocked_next     = unblockable(mask_calc);
                        res.old_handler  = entry.handler;
                        res.old_flags    = entry.flags;
                        res.old_restorer = entry.restorer;
                        res.new_pc       = entry.handler;
                        res.new_sp       = ra;
                        res.ctx_addr     = fa_reg;
                    end
                end
            end
            KIND_SIGRET: begin
                if (active_reg == '0) begin
                    res.status = 1'b1;
                end else begin
                    outcome        = OUT_RESTORE;
                    res.ctx_addr   = active_reg;
                    res.old_bits   = saved_reg;
                    blocked_next   = unblockable(saved_reg);
                    active_next    = '0;
                end
            end
            default: begin
                res.status = 1'b1;
            end
        endcase
    end

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // action table memory
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= act_mem[rd_idx];
        end
        if (exec_done && wr_en) begin
            act_mem[item_sig_m1[IDX_W-1:0]] <= '{
                handler:  item_reg.handler_addr,
                amask:    item_reg.bits,
                flags:    item_reg.flags_word,
                restorer: item_reg.restorer_addr
            };
        end
    end

    // item capture and result register
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_reg     <= in_item;
            kind_reg     <= s_tuser;
            sel_reg      <= sel_next;
            fa_reg       <= fa_next;
            sp_short_reg <= sp_short_next;
            sig_ok_reg   <= sig_ok_next;
        end
        if (m_tvalid_reg == 1'b0 || m_tready) begin
            if (exec_done) begin
                m_tdata_reg <= res;
                m_tuser_reg <= outcome;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_floor_reg <= '0;
            pending_reg     <= '0;
            blocked_reg     <= '0;
            saved_reg       <= '0;
            active_reg      <= '0;
            entry_vld_reg   <= '0;
            rd_vld_reg      <= 1'b0;
            dlv_go_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                stack_floor_reg <= cfg_data;
            end
            if (rd_en) begin
                rd_vld_reg <= entry_vld_reg[rd_idx];
            end
            if (in_accept) begin
                dlv_go_reg <= dlv_go_next;
            end
            if (exec_done) begin
                pending_reg <= pending_next;
                blocked_reg <= blocked_next;
                saved_reg   <= saved_next;
                active_reg  <= active_next;
                if (wr_en) begin
                    entry_vld_reg[item_sig_m1[IDX_W-1:0]] <= 1'b1;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/sigpmd_checker.sv]
// ----------------------------------------------------------------------------
// sigpmd_assert
// Port-level checks of the signal pending mask and delivery controller.
// ----------------------------------------------------------------------------
module sigpmd_assert (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sigpmd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [2:0]                       m_tuser
);
    import sigpmd_pkg::*;

    result_t res;

    assign res = result_t'(m_tdata);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while an item is in work");

    a_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.wake |-> m_tuser == OUT_NONE && !res.status)
        else $error("wake with a delivery outcome or an error");

    a_term_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OUT_TERM |-> res.term_code == {1'b1, res.signal_out})
        else $error("exit code does not match the signal");

    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OUT_HANDLER |->
            res.new_sp == res.ctx_addr - RET_SLOT && res.new_pc == res.old_handler)
        else $error("handler entry frame inconsistent");

endmodule

bind signal_pending_mask_delivery sigpmd_assert u_sigpmd_assert (.*);

[sim/sigpmd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigpmd_checker
// Watches the request, result and stack floor channels of the signal
// controller. Tracks pending set, blocked mask, action table and the active
// handler frame, works out the result of every request and compares each
// result transfer, field by field, with the oldest outstanding reply.
// ----------------------------------------------------------------------------
module sigpmd_checker #(
    parameter int NUM_SIGNALS = 64,
    parameter int FRAME_BYTES = 192
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [sigpmd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [2:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sigpmd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [2:0]                       m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [sigpmd_pkg::ADDR_W-1:0]    cfg_data,
    output int                               replies_due,
    output int                               mismatch_count
);
    import sigpmd_pkg::*;

    typedef struct {
        outcome_t outcome;
        result_t  body;
    } reply_t;

    logic [SET_W-1:0]   pend_set;
    logic [SET_W-1:0]   blk_mask;
    logic [SET_W-1:0]   saved_blk;
    logic [ADDR_W-1:0]  frame_base;
    logic [ADDR_W-1:0]  floor_addr;
    logic [ADDR_W-1:0]  act_handler  [NUM_SIGNALS];
    logic [SET_W-1:0]   act_mask     [NUM_SIGNALS];
    logic [FLAGS_W-1:0] act_flags    [NUM_SIGNALS];
    logic [ADDR_W-1:0]  act_restorer [NUM_SIGNALS];
    reply_t             due_replies  [$];
    int                 errors = 0;

    function automatic logic [SET_W-1:0] sig_bit(input int idx);
        return 64'd1 << idx;
    endfunction

    function automatic logic [SET_W-1:0] strip_kill_stop(input logic [SET_W-1:0] m);
        return m & ~(sig_bit(int'(SIG_KILL) - 1) | sig_bit(int'(SIG_STOP) - 1));
    endfunction

    function automatic reply_t apply_request(input logic [2:0] kind, input item_t it);
        reply_t           rp;
        logic [SET_W-1:0] ready;
        logic [SET_W-1:0] m;
        logic [ADDR_W-1:0] fa;
        logic [SIG_W-1:0] sig;
        logic             sig_valid;
        logic             fault;
        int               idx;
        int               k;
        rp.body    = '0;
        rp.outcome = OUT_NONE;
        m          = blk_mask;
        idx        = int'(it.signal) - 1;
        sig_valid  = (it.signal >= 1) && (int'(it.signal) <= NUM_SIGNALS);
        case (kind)
            KIND_SEND: begin
                if (!sig_valid) begin
                    rp.body.status = 1'b1;
                end else begin
                    pend_set[idx] = 1'b1;
                    rp.body.wake  = 1'b1;
                end
            end
            KIND_SETACT: begin
                if (!sig_valid) begin
                    rp.body.status = 1'b1;
                end else begin
                    rp.body.old_bits     = act_mask[idx];
                    rp.body.old_handler  = act_handler[idx];
                    rp.body.old_flags    = act_flags[idx];
                    rp.body.old_restorer = act_restorer[idx];
                    if (it.has_new) begin
                        if (it.signal == SIG_KILL || it.signal == SIG_STOP) begin
                            rp.body.status = 1'b1;
                        end else begin
                            act_handler[idx]  = it.handler_addr;
                            act_mask[idx]     = it.bits;
                            act_flags[idx]    = it.flags_word;
                            act_restorer[idx] = it.restorer_addr;
                        end
                    end
                end
            end
            KIND_SETMASK: begin
                rp.body.old_bits = blk_mask;
                if (it.has_new) begin
                    case (it.how)
                        HOW_BLOCK:   m = blk_mask | it.bits;
                        HOW_UNBLOCK: m = blk_mask & ~it.bits;
                        HOW_SET:     m = it.bits;
                        default:     rp.body.status = 1'b1;
                    endcase
                    if (!rp.body.status) begin
                        blk_mask = strip_kill_stop(m);
                    end
                end
            end
            KIND_DELIVER: begin
                ready = pend_set & ~blk_mask;
                if (it.is_user && frame_base == '0 && ready != '0) begin
                    idx = 0;
                    for (k = NUM_SIGNALS - 1; k >= 0; k--) begin
                        if (ready[k]) begin
                            idx = k;
                        end
                    end
                    sig                = SIG_W'(idx + 1);
                    pend_set[idx]      = 1'b0;
                    rp.body.signal_out = 7'(idx + 1);
                    if (act_handler[idx] == 48'd1 || (act_handler[idx] == '0 &&
                        (sig == SIG_CHLD || sig == SIG_CONT || sig == SIG_WINCH))) begin
                        rp.outcome = OUT_IGNORED;
                    end else begin
                        fault = act_handler[idx] == '0 || act_restorer[idx] < MIN_RESTORER ||
                                it.stack_ptr < FRAME_BYTES;
                        fa = (it.stack_ptr - ADDR_W'(FRAME_BYTES)) & ~48'hF;
                        if (!fault) begin
                            fault = fa < floor_addr || fa < RET_SLOT ||
                                    (fa - RET_SLOT) < floor_addr;
                        end
                        if (fault) begin
                            rp.outcome         = OUT_TERM;
                            rp.body.term_code  = EXIT_BASE + sig;
                        end else begin
                            saved_blk            = blk_mask;
                            frame_base           = fa;
                            rp.body.old_bits     = blk_mask;
                            blk_mask             = blk_mask | act_mask[idx];
                            if ((act_flags[idx] & NODEFER_BIT) == '0) begin
                                blk_mask[idx] = 1'b1;
                            end
                            blk_mask             = strip_kill_stop(blk_mask);
                            rp.body.old_handler  = act_handler[idx];
                            rp.body.old_flags    = act_flags[idx];
                            rp.body.old_restorer = act_restorer[idx];
                            rp.body.new_pc       = act_handler[idx];
                            rp.body.new_sp       = fa - RET_SLOT;
                            rp.body.ctx_addr     = fa;
                            rp.outcome           = OUT_HANDLER;
                        end
                    end
                end
            end
            KIND_SIGRET: begin
                if (frame_base == '0) begin
                    rp.body.status = 1'b1;
                end else begin
                    rp.outcome         = OUT_RESTORE;
                    rp.body.ctx_addr   = frame_base;
                    rp.body.old_bits   = saved_blk;
                    blk_mask           = strip_kill_stop(saved_blk);
                    frame_base         = '0;
                end
            end
            default: begin
                rp.body.status = 1'b1;
            end
        endcase
        return rp;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        reply_t  want;
        result_t got;
        int      k;
        if (!aresetn) begin
            pend_set   = '0;
            blk_mask   = '0;
            saved_blk  = '0;
            frame_base = '0;
            floor_addr = '0;
            for (k = 0; k < NUM_SIGNALS; k++) begin
                act_handler[k]  = '0;
                act_mask[k]     = '0;
                act_flags[k]    = '0;
                act_restorer[k] = '0;
            end
            due_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                floor_addr = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (due_replies.size() == 0) begin
                    errors++;
                    $display("%0t result: expected none, actual outcome %0d data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = due_replies.pop_front();
                    check_field("status", want.body.status, got.status);
                    check_field("wake", want.body.wake, got.wake);
                    check_field("old_bits", want.body.old_bits, got.old_bits);
                    check_field("old_handler", want.body.old_handler, got.old_handler);
                    check_field("old_flags", want.body.old_flags, got.old_flags);
                    check_field("old_restorer", want.body.old_restorer, got.old_restorer);
                    check_field("outcome", want.outcome, m_tuser);
                    check_field("signal_out", want.body.signal_out, got.signal_out);
                    check_field("term_code", want.body.term_code, got.term_code);
                    check_field("new_pc", want.body.new_pc, got.new_pc);
                    check_field("new_sp", want.body.new_sp, got.new_sp);
                    check_field("ctx_addr", want.body.ctx_addr, got.ctx_addr);
                end
            end
            if (s_tvalid && s_tready) begin
                due_replies.push_back(apply_request(s_tuser, item_t'(s_tdata)));
            end
        end
        replies_due    <= due_replies.size();
        mismatch_count <= errors;
    end

endmodule

[sim/signal_pending_mask_delivery_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_pending_mask_delivery_tb
// Drives requests into the signal controller: a directed pass over invalid
// arguments, protected signals, default and ignore actions, delivery faults,
// handler entry and return, then random request mixes under several stack
// floors, with random gaps on both streams. The checker predicts and compares.
// ----------------------------------------------------------------------------
module signal_pending_mask_delivery_tb;

    import sigpmd_pkg::*;

    localparam logic [HOW_W-1:0]  HOW_INVALID       = 2'd3;
    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
    localparam logic [ADDR_W-1:0] TOP_ADDR          = '1;
    localparam int                IDLE_LIMIT        = 4000;
    localparam int                SETTLE_CYCLES     = 8;
    localparam int                ITEMS_PER_PHASE   = 375;
    localparam int                NUM_SIG_LIMIT     = 64;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [2:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [ADDR_W-1:0]     cfg_data  = '0;
    int                    replies_due;
    int                    mismatch_count;
    logic [ADDR_W-1:0]     cur_floor = '0;
    logic                  quiet     = 1'b0;
    int                    idle_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    signal_pending_mask_delivery uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sigpmd_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .replies_due    (replies_due),
        .mismatch_count (mismatch_count)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin : result_pacing
        int n;
        @(posedge aclk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    task automatic send_request(input logic [2:0] kind, input item_t it);
        int n;
        n = pick_gap();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_floor(input logic [ADDR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_floor = v;
    endtask

    function automatic item_t mk_item(input logic [SIG_W-1:0] sig, input logic [HOW_W-1:0] how,
                                      input logic nw, input logic [SET_W-1:0] bits,
                                      input logic [ADDR_W-1:0] h, input logic [FLAGS_W-1:0] fl,
                                      input logic [ADDR_W-1:0] rs, input logic [ADDR_W-1:0] sp,
                                      input logic usr);
        item_t it;
        it               = '0;
        it.signal        = sig;
        it.how           = how;
        it.has_new       = nw;
        it.bits          = bits;
        it.handler_addr  = h;
        it.flags_word    = fl;
        it.restorer_addr = rs;
        it.stack_ptr     = sp;
        it.is_user       = usr;
        return it;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic void random_request(output logic [2:0] kind, output item_t it);
        int r;
        it = '0;
        r  = $urandom_range(0, 99);
        if (r < 24) begin
            kind = KIND_SEND;
        end else if (r < 38) begin
            kind = KIND_SETACT;
        end else if (r < 50) begin
            kind = KIND_SETMASK;
        end else if (r < 78) begin
            kind = KIND_DELIVER;
        end else if (r < 93) begin
            kind = KIND_SIGRET;
        end else begin
            kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        end

        r = $urandom_range(0, 99);
        if (r < 4) begin
            it.signal = '0;
        end else if (r < 8) begin
            it.signal = 8'($urandom_range(NUM_SIG_LIMIT + 1, 255));
        end else if (r < 25) begin
            case ($urandom_range(0, 4))
                0:       it.signal = SIG_KILL;
                1:       it.signal = SIG_STOP;
                2:       it.signal = SIG_CHLD;
                3:       it.signal = SIG_CONT;
                default: it.signal = SIG_WINCH;
            endcase
        end else if (r < 50) begin
            it.signal = 8'($urandom_range(1, 8));
        end else begin
            it.signal = 8'($urandom_range(1, NUM_SIG_LIMIT));
        end

        r = $urandom_range(0, 9);
        if (r == 0) begin
            it.how = HOW_INVALID;
        end else if (r < 4) begin
            it.how = HOW_BLOCK;
        end else if (r < 7) begin
            it.how = HOW_UNBLOCK;
        end else begin
            it.how = HOW_SET;
        end
        it.has_new = $urandom_range(0, 7) != 0;

        r = $urandom_range(0, 99);
        if (r < 30) begin
            it.bits = {$urandom, $urandom};
        end else if (r < 55) begin
            it.bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        end else if (r < 75) begin
            it.bits = 64'd1 << $urandom_range(0, 63);
        end else if (r < 85) begin
            it.bits = '1;
        end else begin
            it.bits = '0;
        end

        r = $urandom_range(0, 99);
        if (r < 15) begin
            it.handler_addr = '0;
        end else if (r < 30) begin
            it.handler_addr = 48'd1;
        end else if (r < 35) begin
            it.handler_addr = 48'($urandom_range(2, 15));
        end else begin
            it.handler_addr = rand_addr();
        end

        it.flags_word = $urandom;

        r = $urandom_range(0, 99);
        if (r < 8) begin
            it.restorer_addr = '0;
        end else if (r < 15) begin
            it.restorer_addr = 48'd1;
        end else begin
            it.restorer_addr = rand_addr();
        end

        r = $urandom_range(0, 99);
        if (r < 15) begin
            it.stack_ptr = rand_addr();
        end else if (r < 25) begin
            it.stack_ptr = 48'($urandom_range(0, 400));
        end else begin
            it.stack_ptr = cur_floor + 48'($urandom_range(0, 700)) - 48'd64;
        end
        it.is_user = $urandom_range(0, 9) != 0;
    endfunction

    initial begin : stimulus
        logic [ADDR_W-1:0] floors [5];
        logic [2:0]        kind;
        item_t             it;
        int                p;
        int                i;
        floors = '{48'h0, TOP_ADDR, rand_addr(), 48'h7FFF_FFFF_E000, 48'h1000};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_floor('0);

        send_request(KIND_DELIVER, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, TOP_ADDR, 1'b1));
        send_request(KIND_SIGRET, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_SEND, mk_item(8'd0, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_SEND, mk_item(8'd255, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_SETACT, mk_item(8'd0, HOW_BLOCK, 1'b1, '1, TOP_ADDR, '1, TOP_ADDR,
                                          '0, 1'b1));
        send_request(KIND_SETACT, mk_item(8'd5, HOW_BLOCK, 1'b0, '1, TOP_ADDR, '1, TOP_ADDR,
                                          '0, 1'b1));
        send_request(KIND_SETACT, mk_item(SIG_KILL, HOW_BLOCK, 1'b1, '1, 48'h4000, '0, 48'h5000,
                                          '0, 1'b1));
        send_request(KIND_SETMASK, mk_item(8'd1, HOW_INVALID, 1'b1, '1, '0, '0, '0, '0, 1'b1));
        send_request(KIND_SETMASK, mk_item(8'd1, HOW_SET, 1'b1, '1, '0, '0, '0, '0, 1'b1));
        send_request(KIND_SETMASK, mk_item(8'd1, HOW_UNBLOCK, 1'b1, '1, '0, '0, '0, '0, 1'b1));
        send_request(KIND_UNUSED_FIRST, mk_item(8'd1, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_SEND, mk_item(SIG_CHLD, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_DELIVER, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, TOP_ADDR, 1'b1));
        send_request(KIND_SETACT, mk_item(8'd10, HOW_BLOCK, 1'b1, '0, 48'd1, '0, 48'h2000,
                                          '0, 1'b1));
        send_request(KIND_SEND, mk_item(8'd10, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_DELIVER, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, TOP_ADDR, 1'b1));
        send_request(KIND_SEND, mk_item(8'd15, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_DELIVER, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, TOP_ADDR, 1'b1));
        send_request(KIND_SETACT, mk_item(8'd64, HOW_BLOCK, 1'b1, '0, 48'hAB_CD00, '0, 48'd1,
                                          '0, 1'b1));
        send_request(KIND_SEND, mk_item(8'd64, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_DELIVER, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, TOP_ADDR, 1'b1));
        send_request(KIND_SETACT, mk_item(8'd2, HOW_BLOCK, 1'b1, '1, TOP_ADDR, NODEFER_BIT,
                                          48'h1000, '0, 1'b1));
        send_request(KIND_SEND, mk_item(8'd2, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_DELIVER, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, TOP_ADDR, 1'b1));
        send_request(KIND_SIGRET, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_SEND, mk_item(8'd2, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        send_request(KIND_DELIVER, mk_item(8'd1, HOW_BLOCK, 1'b0, '0, '0, '0, '0, 48'd100, 1'b1));

        for (p = 0; p < 5; p++) begin
            wait_drained();
            write_floor(floors[p]);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i % 64 == 0) begin
                    quiet = $urandom_range(0, 3) == 0;
                end
                random_request(kind, it);
                send_request(kind, it);
            end
        end
        wait_drained();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
